/* hdl/qpps_pkg.sv */
// Shared types, constants and the quadrature step table for the position servo.
// Used by every other file of the block; depends on nothing.
package qpps_pkg;

  localparam int unsigned AB_W        = 2;
  localparam int unsigned CMD_W       = 8;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned POS_OUT_W   = 32;
  localparam int unsigned STEP_PROD_W = 17;

  localparam logic [CFG_W-1:0] RESET_PROP_GAIN     = 8'd5;
  localparam logic [CFG_W-1:0] RESET_DERIV_GAIN    = 8'd23;
  localparam logic [CFG_W-1:0] RESET_DUTY_LIMIT    = 8'd255;
  localparam logic [CFG_W-1:0] RESET_SETPOINT_STEP = 8'd5;

  typedef enum logic [1:0] {
    ACT_ENC_INIT   = 2'd0,
    ACT_ENC_SAMPLE = 2'd1,
    ACT_CTRL_TICK  = 2'd2,
    ACT_SERVO_CMD  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN     = 2'd0,
    CFG_DERIV_GAIN    = 2'd1,
    CFG_DUTY_LIMIT    = 2'd2,
    CFG_SETPOINT_STEP = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    QUAD_HOLD = 2'd0,
    QUAD_UP   = 2'd1,
    QUAD_DOWN = 2'd2
  } quad_step_e;

  typedef struct packed {
    action_e                 action;
    logic [AB_W-1:0]         encoder_ab;
    logic                    servo_enable;
    logic signed [CMD_W-1:0] command;
  } item_t;

  typedef struct packed {
    logic     valid;
    item_t    item;
  } stage_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [DUTY_W-1:0] duty_limit;
    logic [CFG_W-1:0]  setpoint_step;
  } cfg_t;

  // Only moves to an adjacent phase count; repeats and two-phase jumps hold.
  function automatic quad_step_e quad_step(logic [AB_W-1:0] phase, logic [AB_W-1:0] ab);
    quad_step_e s;
    unique case ({phase, ab})
      4'b0001: s = QUAD_DOWN;
      4'b0010: s = QUAD_UP;
      4'b0100: s = QUAD_UP;
      4'b0111: s = QUAD_DOWN;
      4'b1000: s = QUAD_DOWN;
      4'b1011: s = QUAD_UP;
      4'b1110: s = QUAD_DOWN;
      4'b1101: s = QUAD_UP;
      default: s = QUAD_HOLD;
    endcase
    return s;
  endfunction

endpackage

/* hdl/qpps_if.sv */
// Valid/ready channel interfaces for the servo's event input and result output.
// Depends on qpps_pkg for field widths.
interface qpps_in_if;
  logic                               valid;
  logic                               ready;
  logic [qpps_pkg::AB_W-1:0]          action;
  logic [qpps_pkg::AB_W-1:0]          encoder_ab;
  logic                               servo_enable;
  logic signed [qpps_pkg::CMD_W-1:0]  command;

  modport source (output valid, action, encoder_ab, servo_enable, command, input ready);
  modport sink   (input valid, action, encoder_ab, servo_enable, command, output ready);
endinterface

interface qpps_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [qpps_pkg::DUTY_W-1:0]           drive_forward;
  logic [qpps_pkg::DUTY_W-1:0]           drive_reverse;
  logic signed [qpps_pkg::POS_OUT_W-1:0] position;

  modport source (output valid, drive_forward, drive_reverse, position, input ready);
  modport sink   (input valid, drive_forward, drive_reverse, position, output ready);
endinterface

/* hdl/quadrature_pd_position_servo_core.sv */
// Quadrature encoder PD position servo, top level: configuration registers,
// input register stage and servo state. Depends on qpps_pkg and qpps_if.
// An accepted event waits in the input register until the state stage takes it; the result
// register loads as the event is taken and offers the result from then on.
// Throughput: one event per cycle while the result channel is not stalled; the limit is the
// combinational path through the two gain multipliers, the response add and the duty clamp.
// Reset: asynchronous, clears all servo state to zero and loads the default gains, duty limit and setpoint step.
module quadrature_pd_position_servo_core #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qpps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qpps_pkg::CFG_W-1:0]          cfg_data_i,
  qpps_in_if.sink                             in_i,
  qpps_out_if.source                          out_o
);

  qpps_pkg::cfg_t   cfg_q, cfg_d;
  qpps_pkg::item_t  in_item;
  qpps_pkg::stage_t stage;
  logic             take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (qpps_pkg::cfg_idx_e'(cfg_idx_i))
        qpps_pkg::CFG_PROP_GAIN:     cfg_d.prop_gain     = cfg_data_i;
        qpps_pkg::CFG_DERIV_GAIN:    cfg_d.deriv_gain    = cfg_data_i;
        qpps_pkg::CFG_DUTY_LIMIT:    cfg_d.duty_limit    = cfg_data_i;
        qpps_pkg::CFG_SETPOINT_STEP: cfg_d.setpoint_step = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= qpps_pkg::RESET_PROP_GAIN;
      cfg_q.deriv_gain    <= qpps_pkg::RESET_DERIV_GAIN;
      cfg_q.duty_limit    <= qpps_pkg::RESET_DUTY_LIMIT;
      cfg_q.setpoint_step <= qpps_pkg::RESET_SETPOINT_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.action       = qpps_pkg::action_e'(in_i.action);
  assign in_item.encoder_ab   = in_i.encoder_ab;
  assign in_item.servo_enable = in_i.servo_enable;
  assign in_item.command      = in_i.command;

  qpps_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .item_i  (in_item),
    .ready_o (in_i.ready),
    .take_i  (take),
    .stage_o (stage)
  );

  qpps_servo_state #(.POSITION_BITS(POSITION_BITS)) u_servo_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .take_o      (take),
    .cfg_i       (cfg_q),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .fwd_o       (out_o.drive_forward),
    .rev_o       (out_o.drive_reverse),
    .position_o  (out_o.position)
  );

endmodule

/* hdl/qpps_in_reg.sv */
// Input register stage: holds one event transaction until the state stage takes it.
// Depends on qpps_pkg for the item and stage types.
module qpps_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  qpps_pkg::item_t  item_i,
  output logic             ready_o,
  input  logic             take_i,
  output qpps_pkg::stage_t stage_o
);

  logic            valid_q, valid_d;
  qpps_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

/* hdl/qpps_pd_law.sv */
// PD control law: error, derivative, exact response, clamp and forward/reverse split.
// Purely combinational; depends on qpps_pkg for the configuration type.
module qpps_pd_law #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic signed [POSITION_BITS-1:0]  target_i,
  input  logic signed [POSITION_BITS-1:0]  tick_i,
  input  logic signed [POSITION_BITS-1:0]  prev_err_i,
  input  qpps_pkg::cfg_t                   cfg_i,
  output logic signed [POSITION_BITS-1:0]  err_o,
  output logic [qpps_pkg::DUTY_W-1:0]      fwd_o,
  output logic [qpps_pkg::DUTY_W-1:0]      rev_o
);

  localparam int unsigned DW = POSITION_BITS + 1;
  // Error times a 9-bit signed gain plus derivative times a 9-bit signed gain.
  localparam int unsigned RW = POSITION_BITS + 11;

  logic signed [POSITION_BITS-1:0] err;
  logic signed [DW-1:0]            deriv;
  logic signed [RW-1:0]            p_term, d_term, resp;
  logic [RW-1:0]                   mag;
  logic [qpps_pkg::DUTY_W-1:0]     sat;
  logic                            neg;

  always_comb begin
    err    = target_i + tick_i;
    deriv  = DW'(err) - DW'(prev_err_i);
    p_term = RW'(err) * RW'($signed({1'b0, cfg_i.prop_gain}));
    d_term = RW'(deriv) * RW'($signed({1'b0, cfg_i.deriv_gain}));
    resp   = p_term + d_term;
    neg    = resp[RW-1];
    mag    = neg ? unsigned'(-resp) : unsigned'(resp);
    sat    = (mag > RW'(cfg_i.duty_limit)) ? cfg_i.duty_limit : mag[qpps_pkg::DUTY_W-1:0];
  end

  assign err_o = err;
  assign fwd_o = neg ? '0 : sat;
  assign rev_o = neg ? sat : '0;

endmodule

/* hdl/qpps_servo_state.sv */
// Servo state and result register: quadrature count, setpoint, last error, duties.
// Depends on qpps_pkg and instantiates qpps_pd_law.
module qpps_servo_state #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  qpps_pkg::stage_t                      stage_i,
  output logic                                  take_o,
  input  qpps_pkg::cfg_t                        cfg_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [qpps_pkg::DUTY_W-1:0]           fwd_o,
  output logic [qpps_pkg::DUTY_W-1:0]           rev_o,
  output logic signed [qpps_pkg::POS_OUT_W-1:0] position_o
);

  localparam int unsigned SPW = qpps_pkg::STEP_PROD_W;
  localparam int unsigned POW = qpps_pkg::POS_OUT_W;
  localparam int unsigned PB  = POSITION_BITS;

  logic [qpps_pkg::AB_W-1:0]   phase_q, phase_d;
  logic signed [PB-1:0]        tick_q, tick_d;
  logic signed [PB-1:0]        target_q, target_d;
  logic signed [PB-1:0]        prev_err_q, prev_err_d;
  logic [qpps_pkg::DUTY_W-1:0] fwd_q, fwd_d, rev_q, rev_d;
  logic                        out_valid_q, out_valid_d;

  logic signed [PB-1:0]        pd_err;
  logic [qpps_pkg::DUTY_W-1:0] pd_fwd, pd_rev;
  logic signed [SPW-1:0]       step_prod;
  logic signed [PB-1:0]        neg_tick;
  qpps_pkg::quad_step_e        qstep;
  qpps_pkg::item_t             item;

  assign item   = stage_i.item;
  // The state only moves when the result register is free, so the duty and
  // count registers double as the output payload.
  assign take_o = stage_i.valid && (!out_valid_q || out_ready_i);

  qpps_pd_law #(.POSITION_BITS(POSITION_BITS)) u_pd_law (
    .target_i   (target_q),
    .tick_i     (tick_q),
    .prev_err_i (prev_err_q),
    .cfg_i      (cfg_i),
    .err_o      (pd_err),
    .fwd_o      (pd_fwd),
    .rev_o      (pd_rev)
  );

  assign qstep     = qpps_pkg::quad_step(phase_q, item.encoder_ab);
  assign step_prod = SPW'($signed({1'b0, cfg_i.setpoint_step})) * SPW'(item.command);

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    target_d   = target_q;
    prev_err_d = prev_err_q;
    fwd_d      = fwd_q;
    rev_d      = rev_q;
    if (take_o) begin
      unique case (item.action)
        qpps_pkg::ACT_ENC_INIT: begin
          phase_d = item.encoder_ab;
          tick_d  = '0;
        end
        qpps_pkg::ACT_ENC_SAMPLE: begin
          unique case (qstep)
            qpps_pkg::QUAD_UP: begin
              phase_d = item.encoder_ab;
              tick_d  = tick_q + PB'(1);
            end
            qpps_pkg::QUAD_DOWN: begin
              phase_d = item.encoder_ab;
              tick_d  = tick_q - PB'(1);
            end
            default: begin
            end
          endcase
        end
        qpps_pkg::ACT_CTRL_TICK: begin
          prev_err_d = pd_err;
          fwd_d      = pd_fwd;
          rev_d      = pd_rev;
        end
        qpps_pkg::ACT_SERVO_CMD: begin
          if (!item.servo_enable) begin
            fwd_d    = '0;
            rev_d    = '0;
            tick_d   = '0;
            target_d = '0;
          end else begin
            // The product always fits in 16 bits, so extending it to the
            // position width is exact.
            target_d = target_q + PB'(step_prod);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      tick_q      <= '0;
      target_q    <= '0;
      prev_err_q  <= '0;
      fwd_q       <= '0;
      rev_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      target_q    <= target_d;
      prev_err_q  <= prev_err_d;
      fwd_q       <= fwd_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign neg_tick    = -tick_q;
  assign out_valid_o = out_valid_q;
  assign fwd_o       = fwd_q;
  assign rev_o       = rev_q;
  assign position_o  = POW'(neg_tick);

  a_duty_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_q != '0 && rev_q != '0))
    else $error("forward and reverse duty are both nonzero");

  a_disable_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item.action == qpps_pkg::ACT_SERVO_CMD && !item.servo_enable
    |=> tick_q == '0 && target_q == '0 && fwd_q == '0 && rev_q == '0)
    else $error("servo disable did not clear count, setpoint and duties");

  a_hold_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item.action == qpps_pkg::ACT_ENC_SAMPLE && qstep == qpps_pkg::QUAD_HOLD
    |=> $stable(tick_q) && $stable(phase_q))
    else $error("ignored encoder sample changed the count or phase");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(tick_q) && $stable(fwd_q) && $stable(rev_q))
    else $error("state moved while a result transaction was stalled");

endmodule

/* sim/quadrature_pd_position_servo_core_tb.sv */
// Self-checking testbench for the quadrature PD position servo: a directed table and a
// sweep of register settings with random events, checked against a predictor.
// Depends on qpps_pkg, qpps_if and the quadrature_pd_position_servo_core RTL.
module quadrature_pd_position_servo_core_tb;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_EVENTS  = 105;
  localparam int NUM_PHASES    = 6;
  localparam int RANDOM_REG    = -1;

  typedef struct {
    logic [qpps_pkg::DUTY_W-1:0]           fwd;
    logic [qpps_pkg::DUTY_W-1:0]           rev;
    logic signed [qpps_pkg::POS_OUT_W-1:0] pos;
  } servo_reading_t;

  typedef struct packed {
    qpps_pkg::action_e              act;
    logic [qpps_pkg::AB_W-1:0]      ab;
    logic                           en;
    logic [qpps_pkg::CMD_W-1:0]     cmd;
    logic                           typed;
    logic [qpps_pkg::DUTY_W-1:0]    fwd;
    logic [qpps_pkg::DUTY_W-1:0]    rev;
    logic [qpps_pkg::POS_OUT_W-1:0] pos;
  } directed_row_t;

  // Reset gains throughout; the encoder walks through every legal move in both directions.
  localparam directed_row_t DIRECTED_ROWS [0:21] = '{
    '{qpps_pkg::ACT_CTRL_TICK,  2'd0, 1'b0, 8'h00, 1'b1, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_INIT,   2'd3, 1'b0, 8'h00, 1'b1, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd3, 1'b0, 8'h00, 1'b1, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd0, 1'b0, 8'h00, 1'b1, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd1, 1'b0, 8'h00, 1'b1, 8'd0, 8'd0, 32'hFFFF_FFFF},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd2, 1'b0, 8'h00, 1'b1, 8'd0, 8'd0, 32'hFFFF_FFFF},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd0, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd2, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd3, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd2, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd0, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd1, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_SAMPLE, 2'd3, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_SERVO_CMD,  2'd0, 1'b1, 8'h7F, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_CTRL_TICK,  2'd1, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_SERVO_CMD,  2'd2, 1'b1, 8'h80, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_CTRL_TICK,  2'd3, 1'b1, 8'hFF, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_SERVO_CMD,  2'd1, 1'b0, 8'hAA, 1'b1, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_CTRL_TICK,  2'd0, 1'b0, 8'h00, 1'b0, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_CTRL_TICK,  2'd0, 1'b0, 8'h00, 1'b1, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_ENC_INIT,   2'd2, 1'b1, 8'h55, 1'b1, 8'd0, 8'd0, 32'h0000_0000},
    '{qpps_pkg::ACT_SERVO_CMD,  2'd0, 1'b1, 8'h00, 1'b1, 8'd0, 8'd0, 32'h0000_0000}
  };

  // Gains, limit and step per phase; a negative entry draws a random value.
  localparam int REG_SWEEP [0:NUM_PHASES-1][0:3] = '{
    '{255, 255, 255, 255},
    '{0, 0, 0, 0},
    '{1, 0, 1, 1},
    '{0, 255, 128, 3},
    '{RANDOM_REG, RANDOM_REG, RANDOM_REG, RANDOM_REG},
    '{RANDOM_REG, RANDOM_REG, RANDOM_REG, RANDOM_REG}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [qpps_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [qpps_pkg::CFG_W-1:0]     cfg_data_i;

  qpps_in_if  evt_if ();
  qpps_out_if res_if ();

  quadrature_pd_position_servo_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (evt_if),
    .out_o      (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Servo state as the testbench tracks it.
  int                          gain_p;
  int                          gain_d;
  int                          duty_max;
  int                          step_size;
  logic [qpps_pkg::AB_W-1:0]   enc_phase;
  logic signed [31:0]          servo_count;
  logic signed [31:0]          servo_target;
  logic signed [31:0]          servo_last_error;
  logic [qpps_pkg::DUTY_W-1:0] fwd_duty;
  logic [qpps_pkg::DUTY_W-1:0] rev_duty;

  servo_reading_t expected_readings [$];
  int             mismatches;
  int             events_sent;
  int             readings_seen;
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             hold_request;

  function automatic logic [qpps_pkg::AB_W-1:0] adjacent_ab(logic [qpps_pkg::AB_W-1:0] phase,
                                                            bit up);
    case (phase)
      2'd0: return up ? 2'd2 : 2'd1;
      2'd1: return up ? 2'd0 : 2'd3;
      2'd2: return up ? 2'd3 : 2'd0;
      default: return up ? 2'd1 : 2'd2;
    endcase
  endfunction

  task automatic advance_servo(input qpps_pkg::item_t ev, output servo_reading_t r);
    logic signed [31:0] err;
    longint             diff;
    longint             resp;
    longint             mag;
    case (ev.action)
      qpps_pkg::ACT_ENC_INIT: begin
        enc_phase   = ev.encoder_ab;
        servo_count = '0;
      end
      qpps_pkg::ACT_ENC_SAMPLE: begin
        if (ev.encoder_ab == adjacent_ab(enc_phase, 1'b1)) begin
          servo_count = servo_count + 1;
          enc_phase   = ev.encoder_ab;
        end else if (ev.encoder_ab == adjacent_ab(enc_phase, 1'b0)) begin
          servo_count = servo_count - 1;
          enc_phase   = ev.encoder_ab;
        end
      end
      qpps_pkg::ACT_CTRL_TICK: begin
        // The error wraps at the position width; derivative and response do not.
        err  = servo_target + servo_count;
        diff = longint'(err) - longint'(servo_last_error);
        resp = longint'(gain_p) * longint'(err) + longint'(gain_d) * diff;
        servo_last_error = err;
        mag = (resp < 0) ? -resp : resp;
        if (mag > duty_max) mag = duty_max;
        fwd_duty = (resp > 0) ? mag[7:0] : '0;
        rev_duty = (resp < 0) ? mag[7:0] : '0;
      end
      default: begin
        if (!ev.servo_enable) begin
          fwd_duty     = '0;
          rev_duty     = '0;
          servo_count  = '0;
          servo_target = '0;
        end else begin
          servo_target = servo_target + step_size * int'($signed(ev.command));
        end
      end
    endcase
    r.fwd = fwd_duty;
    r.rev = rev_duty;
    r.pos = -servo_count;
  endtask

  // A random mix of events; encoder samples are mostly legal moves from the current phase, so the count really moves.
  function automatic qpps_pkg::item_t random_event();
    qpps_pkg::item_t ev;
    int              pick;
    pick            = int'($urandom_range(99));
    ev.encoder_ab   = 2'($urandom_range(3));
    ev.servo_enable = 1'($urandom_range(1));
    ev.command      = 8'($urandom_range(255));
    if (pick < 45) begin
      ev.action = qpps_pkg::ACT_ENC_SAMPLE;
      if ($urandom_range(9) < 8) ev.encoder_ab = adjacent_ab(enc_phase, 1'($urandom_range(1)));
    end else if (pick < 72) begin
      ev.action = qpps_pkg::ACT_CTRL_TICK;
    end else if (pick < 92) begin
      ev.action       = qpps_pkg::ACT_SERVO_CMD;
      ev.servo_enable = ($urandom_range(9) != 0);
    end else if (pick < 96) begin
      ev.action = qpps_pkg::ACT_ENC_INIT;
    end else begin
      ev.action = qpps_pkg::action_e'($urandom_range(3));
    end
    return ev;
  endfunction

  task automatic push_event(input qpps_pkg::item_t ev, input bit typed,
                            input servo_reading_t typed_r);
    servo_reading_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_if.valid        <= 1'b1;
    evt_if.action       <= ev.action;
    evt_if.encoder_ab   <= ev.encoder_ab;
    evt_if.servo_enable <= ev.servo_enable;
    evt_if.command      <= ev.command;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    advance_servo(ev, r);
    expected_readings.push_back(typed ? typed_r : r);
    events_sent++;
  endtask

  task automatic drain_events();
    evt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(input int p, input int d, input int l, input int s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= qpps_pkg::CFG_PROP_GAIN;
    cfg_data_i <= p[7:0];
    @(posedge clk_i);
    cfg_idx_i  <= qpps_pkg::CFG_DERIV_GAIN;
    cfg_data_i <= d[7:0];
    @(posedge clk_i);
    cfg_idx_i  <= qpps_pkg::CFG_DUTY_LIMIT;
    cfg_data_i <= l[7:0];
    @(posedge clk_i);
    cfg_idx_i  <= qpps_pkg::CFG_SETPOINT_STEP;
    cfg_data_i <= s[7:0];
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    gain_p    = p;
    gain_d    = d;
    duty_max  = l;
    step_size = s;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    servo_reading_t exp_r;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction fwd=%0d rev=%0d pos=%0d",
                                  res_if.drive_forward, res_if.drive_reverse, res_if.position));
      end else begin
        exp_r = expected_readings.pop_front();
        if (res_if.drive_forward !== exp_r.fwd)
          report_mismatch($sformatf("drive_forward %0d, expected %0d",
                                    res_if.drive_forward, exp_r.fwd));
        if (res_if.drive_reverse !== exp_r.rev)
          report_mismatch($sformatf("drive_reverse %0d, expected %0d",
                                    res_if.drive_reverse, exp_r.rev));
        if (res_if.position !== exp_r.pos)
          report_mismatch($sformatf("position %0d, expected %0d", res_if.position, exp_r.pos));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    servo_reading_t  typed_r;
    qpps_pkg::item_t ev;
    int              regs [4];

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= qpps_pkg::CFG_PROP_GAIN;
    cfg_data_i          <= '0;
    evt_if.valid        <= 1'b0;
    evt_if.action       <= qpps_pkg::ACT_ENC_INIT;
    evt_if.encoder_ab   <= '0;
    evt_if.servo_enable <= 1'b0;
    evt_if.command      <= '0;
    send_idle_pct    = 21;
    recv_stall_pct   = 21;
    hold_request     = 1'b0;
    mismatches       = 0;
    events_sent      = 0;
    readings_seen    = 0;
    gain_p           = int'(qpps_pkg::RESET_PROP_GAIN);
    gain_d           = int'(qpps_pkg::RESET_DERIV_GAIN);
    duty_max         = int'(qpps_pkg::RESET_DUTY_LIMIT);
    step_size        = int'(qpps_pkg::RESET_SETPOINT_STEP);
    enc_phase        = '0;
    servo_count      = '0;
    servo_target     = '0;
    servo_last_error = '0;
    fwd_duty         = '0;
    rev_duty         = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      ev.action       = DIRECTED_ROWS[i].act;
      ev.encoder_ab   = DIRECTED_ROWS[i].ab;
      ev.servo_enable = DIRECTED_ROWS[i].en;
      ev.command      = DIRECTED_ROWS[i].cmd;
      typed_r.fwd     = DIRECTED_ROWS[i].fwd;
      typed_r.rev     = DIRECTED_ROWS[i].rev;
      typed_r.pos     = DIRECTED_ROWS[i].pos;
      push_event(ev, DIRECTED_ROWS[i].typed, typed_r);
    end
    drain_events();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      foreach (regs[k]) begin
        regs[k] = (REG_SWEEP[ph][k] < 0) ? int'($urandom_range(255)) : REG_SWEEP[ph][k];
      end
      load_settings(regs[0], regs[1], regs[2], regs[3]);
      // One phase runs with no idling on either side.
      send_idle_pct  = (ph == 3) ? 0 : 21;
      recv_stall_pct = (ph == 3) ? 0 : 21;
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        if (ph == 0 && n == 30) hold_request = 1'b1;
        push_event(random_event(), 1'b0, typed_r);
      end
      drain_events();
    end
    repeat (8) @(posedge clk_i);

    $display("Ran %0d events and checked %0d results over %0d register settings,",
             events_sent, readings_seen, NUM_PHASES + 1);
    $display("including a long receiver hold-off, zero and full gains and a zero duty limit.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
